FILE: rtl/epoch_seconds_to_calendar_date_defines.svh
// Assertion macros shared by the epoch-to-calendar block.
// Included by the top level; depends on nothing else.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ECD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ECD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecd: next-cycle check failed");

`endif

FILE: rtl/ecd_pkg.sv
// Shared types, constants and the month table of the epoch-to-calendar block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ecd_pkg;

    // Pipeline layout: three stages split days from seconds, six more build the fields.
    localparam int unsigned DAY_STAGES   = 3;
    localparam int unsigned FIELD_STAGES = 6;
    localparam int unsigned NUM_STAGES   = DAY_STAGES + FIELD_STAGES;

    typedef logic [15:0] days_t;
    typedef logic [16:0] sod_t;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;

    // s / 86400 = (s >> 7) / 675, estimated by a reciprocal, low by at most one.
    localparam int unsigned DAY_PRE_SHIFT = 7;
    localparam logic [25:0] DAY_RCP       = 26'd50903316;
    localparam int unsigned DAY_RCP_SHIFT = 35;

    // sod / 3600 = (sod >> 4) / 225.
    localparam int unsigned HOUR_PRE_SHIFT = 4;
    localparam logic [12:0] HOUR_RCP       = 13'd4660;
    localparam int unsigned HOUR_RCP_SHIFT = 20;

    // rem / 60 = (rem >> 2) / 15.
    localparam int unsigned MIN_PRE_SHIFT = 2;
    localparam logic [10:0] MIN_RCP       = 11'd1092;
    localparam int unsigned MIN_RCP_SHIFT = 14;

    // Days are counted from 1968-01-01, the start of a four-year cycle.
    localparam logic [11:0] CYCLE_BASE_YEAR   = 12'd1968;
    localparam logic [15:0] EPOCH_DAY_OFFSET  = 16'd731;
    localparam logic [15:0] DAYS_PER_CYCLE    = 16'd1461;
    localparam logic [10:0] YEAR1_START       = 11'd366;
    localparam logic [10:0] YEAR2_START       = 11'd731;
    localparam logic [10:0] YEAR3_START       = 11'd1096;
    localparam logic [10:0] DAY_RCP_CYC       = 11'd1435;
    localparam int unsigned CYC_RCP_SHIFT     = 21;

    // 2100 is the only century year in range that is not a leap year.
    localparam logic [11:0] CENTURY_YEAR      = 12'd2100;
    localparam logic [15:0] DAY_CENTURY_MAR1  = 16'd47541;

    // Zero-based day of the year on which month idx (0 = January) starts.
    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (idx inside {[4'd2:4'd11]}))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

FILE: rtl/ecd_stamp_if.sv
// Input channel of the epoch-to-calendar block: a 32-bit seconds count.
// Standalone; depends on nothing.
`timescale 1ns / 1ps

interface ecd_stamp_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

FILE: rtl/ecd_civil_if.sv
// Output channel of the epoch-to-calendar block: civil date and time of day.
// Standalone; depends on nothing.
`timescale 1ns / 1ps

interface ecd_civil_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [8:0]  day_in_year;
    logic [5:0]  leap_count;

    modport source (output valid, output year, output month, output day, output hour,
                    output minute, output second, output day_in_year, output leap_count,
                    input ready);
    modport sink   (input valid, input year, input month, input day, input hour,
                    input minute, input second, input day_in_year, input leap_count,
                    output ready);
endinterface

FILE: rtl/ecd_day_split.sv
// Three-stage split of a seconds count into whole days and second of day.
// Depends on ecd_pkg.
`timescale 1ns / 1ps

module ecd_day_split (
    input  logic                             clk,
    input  logic [ecd_pkg::DAY_STAGES-1:0]   en,
    input  logic [31:0]                      epoch_seconds,
    output ecd_pkg::days_t                   days,
    output ecd_pkg::sod_t                    sod
);
    import ecd_pkg::*;

    logic [31:0] s1_reg;
    logic [50:0] p1_reg;
    logic [50:0] p1_next;
    logic [31:0] s2_reg;
    logic [15:0] q2_reg;
    logic [15:0] q2_next;
    logic [31:0] pd2_reg;
    logic [31:0] pd2_next;
    days_t       days_reg;
    days_t       days_next;
    sod_t        sod_reg;
    sod_t        sod_next;
    logic [17:0] r3;
    logic        corr3;

    always_comb
    begin
        p1_next   = 51'(epoch_seconds >> DAY_PRE_SHIFT) * 51'(DAY_RCP);
        q2_next   = 16'(p1_reg >> DAY_RCP_SHIFT);
        pd2_next  = 32'(33'(q2_next) * 33'(SECS_PER_DAY));
        // The estimate is at most one day short; one compare fixes it.
        r3        = 18'(s2_reg - pd2_reg);
        corr3     = (r3 >= 18'(SECS_PER_DAY));
        days_next = q2_reg + 16'(corr3);
        sod_next  = corr3 ? 17'(r3 - 18'(SECS_PER_DAY)) : 17'(r3);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_reg <= epoch_seconds;
            p1_reg <= p1_next;
        end
        if (en[1])
        begin
            s2_reg  <= s1_reg;
            q2_reg  <= q2_next;
            pd2_reg <= pd2_next;
        end
        if (en[2])
        begin
            days_reg <= days_next;
            sod_reg  <= sod_next;
        end
    end

    assign days = days_reg;
    assign sod  = sod_reg;

endmodule

FILE: rtl/ecd_time_split.sv
// Six-stage split of the second of day into hour, minute and second.
// Depends on ecd_pkg.
`timescale 1ns / 1ps

module ecd_time_split (
    input  logic                             clk,
    input  logic [ecd_pkg::FIELD_STAGES-1:0] en,
    input  ecd_pkg::sod_t                    sod,
    output logic [4:0]                       hour,
    output logic [5:0]                       minute,
    output logic [5:0]                       second
);
    import ecd_pkg::*;

    sod_t        sod4_reg;
    logic [25:0] hp4_reg;
    logic [25:0] hp4_next;
    sod_t        sod5_reg;
    logic [4:0]  hq5_reg;
    logic [4:0]  hq5_next;
    logic [16:0] ph5_reg;
    logic [16:0] ph5_next;
    logic [12:0] rh6;
    logic        corr6;
    logic [4:0]  hour6_reg;
    logic [4:0]  hour6_next;
    logic [11:0] remh6_reg;
    logic [11:0] remh6_next;
    logic [4:0]  hour7_reg;
    logic [11:0] remh7_reg;
    logic [20:0] mp7_reg;
    logic [20:0] mp7_next;
    logic [4:0]  hour8_reg;
    logic [11:0] remh8_reg;
    logic [5:0]  mq8_reg;
    logic [5:0]  mq8_next;
    logic [11:0] pm8_reg;
    logic [11:0] pm8_next;
    logic [6:0]  rm9;
    logic        corr9;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  minute_next;
    logic [5:0]  second_reg;
    logic [5:0]  second_next;

    always_comb
    begin
        hp4_next    = 26'(sod >> HOUR_PRE_SHIFT) * 26'(HOUR_RCP);
        hq5_next    = 5'(hp4_reg >> HOUR_RCP_SHIFT);
        ph5_next    = 17'(hq5_next) * SECS_PER_HOUR;
        rh6         = 13'(sod5_reg - ph5_reg);
        corr6       = (rh6 >= 13'(SECS_PER_HOUR));
        hour6_next  = hq5_reg + 5'(corr6);
        remh6_next  = corr6 ? 12'(rh6 - 13'(SECS_PER_HOUR)) : 12'(rh6);
        mp7_next    = 21'(remh6_reg >> MIN_PRE_SHIFT) * 21'(MIN_RCP);
        mq8_next    = 6'(mp7_reg >> MIN_RCP_SHIFT);
        pm8_next    = 12'(mq8_next) * SECS_PER_MIN;
        rm9         = 7'(remh8_reg - pm8_reg);
        corr9       = (rm9 >= 7'(SECS_PER_MIN));
        minute_next = mq8_reg + 6'(corr9);
        second_next = corr9 ? 6'(rm9 - 7'(SECS_PER_MIN)) : 6'(rm9);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sod4_reg <= sod;
            hp4_reg  <= hp4_next;
        end
        if (en[1])
        begin
            sod5_reg <= sod4_reg;
            hq5_reg  <= hq5_next;
            ph5_reg  <= ph5_next;
        end
        if (en[2])
        begin
            hour6_reg <= hour6_next;
            remh6_reg <= remh6_next;
        end
        if (en[3])
        begin
            hour7_reg <= hour6_reg;
            remh7_reg <= remh6_reg;
            mp7_reg   <= mp7_next;
        end
        if (en[4])
        begin
            hour8_reg <= hour7_reg;
            remh8_reg <= remh7_reg;
            mq8_reg   <= mq8_next;
            pm8_reg   <= pm8_next;
        end
        if (en[5])
        begin
            hour_reg   <= hour8_reg;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

    assign hour   = hour_reg;
    assign minute = minute_reg;
    assign second = second_reg;

endmodule

FILE: rtl/ecd_date_split.sv
// Six-stage conversion of a day count into year, month, day and year statistics.
// Depends on ecd_pkg.
`timescale 1ns / 1ps

module ecd_date_split (
    input  logic                             clk,
    input  logic [ecd_pkg::FIELD_STAGES-1:0] en,
    input  ecd_pkg::days_t                   days,
    output logic [11:0]                      year,
    output logic [3:0]                       month,
    output logic [4:0]                       day,
    output logic [8:0]                       day_in_year,
    output logic [5:0]                       leap_count
);
    import ecd_pkg::*;

    // Dates from March 1, 2100 on are moved one day forward, so that a plain
    // every-fourth-year rule holds over the whole range; the missing leap day
    // is then taken back out of the ordinal day and the leap count.
    logic        adj4_next;
    days_t       d4_next;
    logic        adj4_reg;
    days_t       d4_reg;
    logic [26:0] p4_reg;
    logic [26:0] p4_next;
    logic        adj5_reg;
    days_t       d5_reg;
    logic [5:0]  c5_reg;
    logic [5:0]  c5_next;
    logic [15:0] pc5_reg;
    logic [15:0] pc5_next;
    logic [11:0] r6;
    logic        corr6;
    logic        adj6_reg;
    logic [5:0]  c6_reg;
    logic [5:0]  c6_next;
    logic [10:0] r6_reg;
    logic [10:0] r6_next;
    logic [1:0]  yc7;
    logic [10:0] ybase7;
    logic        adj7_reg;
    logic [11:0] year7_reg;
    logic [11:0] year7_next;
    logic [8:0]  doy7_reg;
    logic [8:0]  doy7_next;
    logic        leap7_reg;
    logic [5:0]  lc7_reg;
    logic [5:0]  lc7_next;
    logic [3:0]  mon8_next;
    logic [3:0]  mon8_reg;
    logic [8:0]  doy8_reg;
    logic        leap8_reg;
    logic [11:0] year8_reg;
    logic [5:0]  lc8_reg;
    logic [5:0]  lc8_next;
    logic [8:0]  ord8_reg;
    logic [8:0]  ord8_next;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [4:0]  day_next;
    logic [8:0]  ord_reg;
    logic [5:0]  lc_reg;

    always_comb
    begin
        adj4_next = (days >= DAY_CENTURY_MAR1);
        d4_next   = days + EPOCH_DAY_OFFSET + 16'(adj4_next);
        p4_next   = 27'(d4_next) * 27'(DAY_RCP_CYC);
        c5_next   = 6'(p4_reg >> CYC_RCP_SHIFT);
        pc5_next  = 16'(c5_next) * DAYS_PER_CYCLE;
        r6        = 12'(d5_reg - pc5_reg);
        corr6     = (r6 >= 12'(DAYS_PER_CYCLE));
        c6_next   = c5_reg + 6'(corr6);
        r6_next   = corr6 ? 11'(r6 - 12'(DAYS_PER_CYCLE)) : 11'(r6);

        // Year within the cycle: the first is the leap year.
        if (r6_reg >= YEAR3_START)
        begin
            yc7    = 2'd3;
            ybase7 = YEAR3_START;
        end
        else if (r6_reg >= YEAR2_START)
        begin
            yc7    = 2'd2;
            ybase7 = YEAR2_START;
        end
        else if (r6_reg >= YEAR1_START)
        begin
            yc7    = 2'd1;
            ybase7 = YEAR1_START;
        end
        else
        begin
            yc7    = 2'd0;
            ybase7 = 11'd0;
        end
        doy7_next  = 9'(r6_reg - ybase7);
        year7_next = CYCLE_BASE_YEAR + 12'({c6_reg, 2'b00}) + 12'(yc7);
        lc7_next   = c6_reg - 6'(yc7 == 2'd0);

        mon8_next = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            mon8_next = mon8_next + 4'(doy7_reg >= month_start(4'(i), leap7_reg));
        end
        lc8_next  = lc7_reg - 6'(year7_reg > CENTURY_YEAR);
        ord8_next = doy7_reg + 9'd1 - 9'((year7_reg == CENTURY_YEAR) && adj7_reg);

        day_next = 5'(doy8_reg - month_start(mon8_reg, leap8_reg) + 9'd1);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            adj4_reg <= adj4_next;
            d4_reg   <= d4_next;
            p4_reg   <= p4_next;
        end
        if (en[1])
        begin
            adj5_reg <= adj4_reg;
            d5_reg   <= d4_reg;
            c5_reg   <= c5_next;
            pc5_reg  <= pc5_next;
        end
        if (en[2])
        begin
            adj6_reg <= adj5_reg;
            c6_reg   <= c6_next;
            r6_reg   <= r6_next;
        end
        if (en[3])
        begin
            adj7_reg  <= adj6_reg;
            year7_reg <= year7_next;
            doy7_reg  <= doy7_next;
            leap7_reg <= (yc7 == 2'd0);
            lc7_reg   <= lc7_next;
        end
        if (en[4])
        begin
            mon8_reg  <= mon8_next;
            doy8_reg  <= doy7_reg;
            leap8_reg <= leap7_reg;
            year8_reg <= year7_reg;
            lc8_reg   <= lc8_next;
            ord8_reg  <= ord8_next;
        end
        if (en[5])
        begin
            year_reg  <= year8_reg;
            month_reg <= mon8_reg + 4'd1;
            day_reg   <= day_next;
            ord_reg   <= ord8_reg;
            lc_reg    <= lc8_reg;
        end
    end

    assign year        = year_reg;
    assign month       = month_reg;
    assign day         = day_reg;
    assign day_in_year = ord_reg;
    assign leap_count  = lc_reg;

endmodule

FILE: rtl/epoch_seconds_to_calendar_date.sv
// Converts a count of seconds since 1970-01-01 00:00:00 UTC into the civil
// Gregorian date and time of day, one transfer in and one transfer out for each
// item. The block is a nine-stage pipeline: it takes a new seconds count in every
// cycle, provided the output side keeps taking results, and each result moves
// through the stage registers in order. The depth is set by the chain of constant
// divisions (by 86400, then by 3600 and 60 for the time of day, by 1461 for the
// four-year cycles of the date), each done as a registered reciprocal multiply,
// a registered back-multiply and a one-step correction. Each stage holds a valid
// bit; a stage advances when it is empty or the stage after it advances, so a
// stall on the output fills the empty stages first and only then holds off input
// transfers. All 2^32 input values are legal and reach 2106-02-07 06:28:15.
// Depends on ecd_pkg, ecd_stamp_if, ecd_civil_if, ecd_day_split, ecd_time_split,
// ecd_date_split and the assertion macro header.
`timescale 1ns / 1ps
`include "epoch_seconds_to_calendar_date_defines.svh"

module epoch_seconds_to_calendar_date (
    input  logic       clk,
    input  logic       rst_n,
    ecd_stamp_if.sink  stamp,
    ecd_civil_if.source civil
);
    import ecd_pkg::*;

    // One valid bit per pipeline stage; the last stage is the output register.
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] en;

    days_t days;
    sod_t  sod;

    // A stage loads when it is empty or when its content moves on. The chain
    // runs from the output back to the input, so bubbles are squeezed out.
    always_comb
    begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || civil.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        v_next[0] = en[0] ? stamp.valid : v_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign stamp.ready = en[0];
    assign civil.valid = v_reg[NUM_STAGES-1];

    // Stages one to three: whole days and the second within the day.
    ecd_day_split u_day_split (
        .clk           (clk),
        .en            (en[DAY_STAGES-1:0]),
        .epoch_seconds (stamp.epoch_seconds),
        .days          (days),
        .sod           (sod)
    );

    // Stages four to nine, time of day: hour, minute and second.
    ecd_time_split u_time_split (
        .clk    (clk),
        .en     (en[NUM_STAGES-1:DAY_STAGES]),
        .sod    (sod),
        .hour   (civil.hour),
        .minute (civil.minute),
        .second (civil.second)
    );

    // Stages four to nine, in parallel with the time of day: the calendar date.
    // Day counts are taken relative to 1968-01-01 and split into four-year
    // cycles; the century year 2100 is handled by skipping its missing leap day.
    ecd_date_split u_date_split (
        .clk         (clk),
        .en          (en[NUM_STAGES-1:DAY_STAGES]),
        .days        (days),
        .year        (civil.year),
        .month       (civil.month),
        .day         (civil.day),
        .day_in_year (civil.day_in_year),
        .leap_count  (civil.leap_count)
    );

    // With every stage full and the output held, no new transfer may be taken.
    `ECD_ASSERT_IMP(a_full_stall_blocks, clk, rst_n, (&v_reg) && !civil.ready, !stamp.ready)

    // In January the ordinal day equals the day of the month.
    `ECD_ASSERT_IMP(a_january_ordinal, clk, rst_n, civil.valid && (civil.month == 4'd1), civil.day_in_year == 9'(civil.day))

    // From 2105 on, every leap year up to 2104 is counted and 2100 is not.
    `ECD_ASSERT_IMP(a_late_leap_count, clk, rst_n, civil.valid && (civil.year >= 12'd2105), civil.leap_count == 6'd33)

endmodule

FILE: dv/epoch_seconds_to_calendar_date_tb.sv
// Self-checking testbench for epoch_seconds_to_calendar_date: drives seconds counts
// through the stamp channel and checks every civil date and time that comes back.
// Depends on ecd_pkg, ecd_stamp_if, ecd_civil_if and the block's RTL.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_date_tb;

    import ecd_pkg::*;

    localparam int unsigned CLK_PERIOD     = 12;
    localparam int unsigned RESET_CYCLES   = 6;
    localparam int unsigned RANDOM_ITEMS   = 400;
    localparam int unsigned CALM_TAIL      = 60;
    localparam int unsigned MAX_BURST      = 18;
    localparam int unsigned DRAIN_CYCLES   = 4 * NUM_STAGES + 8;
    localparam int unsigned TIMEOUT_CYCLES = 200000;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned SECS_IN_DAY    = 86400;
    localparam int unsigned SECS_IN_HOUR   = 3600;
    localparam int unsigned FIRST_YEAR     = 1970;
    localparam int unsigned LAST_YEAR      = 2106;
    localparam longint      LARGEST_STAMP  = 64'd4294967295;

    // One civil result, field for field as it appears on the output channel.
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [8:0]  day_in_year;
        logic [5:0]  leap_count;
    } civil_t;

    // A date still owed by the block, kept with the count that caused it.
    typedef struct packed {
        logic [31:0] stamp;
        civil_t      date;
    } owed_date_t;

    // A directed row. Where known_date is set the date is typed in by hand;
    // otherwise the date predictor works it out.
    typedef struct packed {
        logic [31:0] stamp;
        logic        known_date;
        civil_t      date;
    } stim_row_t;

    localparam int unsigned NUM_ROWS = 24;

    // The first six rows carry hand-checked dates: the epoch itself, the largest
    // count, the ends of the first day and of the first year. The rest cover leap
    // days, leap-year ends, the 2100 century year, the 2038 sign boundary and
    // alternating bit patterns, and are predicted.
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{32'd0,          1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  9'd1,   6'd0}},
        '{32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2,  5'd7,  5'd6,  6'd28, 6'd15, 9'd38,  6'd33}},
        '{32'd86399,      1'b1, '{12'd1970, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59, 9'd1,   6'd0}},
        '{32'd86400,      1'b1, '{12'd1970, 4'd1,  5'd2,  5'd0,  6'd0,  6'd0,  9'd2,   6'd0}},
        '{32'd31535999,   1'b1, '{12'd1970, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 9'd365, 6'd0}},
        '{32'd31536000,   1'b1, '{12'd1971, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  9'd1,   6'd0}},
        '{32'd68169599,   1'b0, '0},
        '{32'd68169600,   1'b0, '0},
        '{32'd94694399,   1'b0, '0},
        '{32'd94694400,   1'b0, '0},
        '{32'd951782400,  1'b0, '0},
        '{32'd978220800,  1'b0, '0},
        '{32'd978307199,  1'b0, '0},
        '{32'd978307200,  1'b0, '0},
        '{32'd2147483647, 1'b0, '0},
        '{32'd2147483648, 1'b0, '0},
        '{32'd4102444799, 1'b0, '0},
        '{32'd4107542399, 1'b0, '0},
        '{32'd4107542400, 1'b0, '0},
        '{32'd4133980799, 1'b0, '0},
        '{32'd4133980800, 1'b0, '0},
        '{32'h5555_5555,  1'b0, '0},
        '{32'hAAAA_AAAA,  1'b0, '0},
        '{32'hFFFF_0000,  1'b0, '0}
    };

    logic clk;
    logic rst_n;

    ecd_stamp_if stamp_ch ();
    ecd_civil_if civil_ch ();

    epoch_seconds_to_calendar_date dut (
        .clk   (clk),
        .rst_n (rst_n),
        .stamp (stamp_ch),
        .civil (civil_ch)
    );

    owed_date_t  owed_dates [$];
    int unsigned error_count;
    int unsigned dates_checked;
    int unsigned random_sent;
    int unsigned first_year_seen;
    int unsigned last_year_seen;
    int unsigned leap_days_seen;
    // Idling density shared by both sides: 0 means no idling at all, larger
    // values make bursts rarer.
    int unsigned idle_rate;
    int unsigned stall_left;

    // ---------------------------------------------------------------------
    // Calendar arithmetic used by the date predictor and the stimulus.
    // ---------------------------------------------------------------------

    // Gregorian 4/100/400 rule; returns 1 for a leap year.
    function automatic int unsigned leap_year(input int unsigned yr);
        return (((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0) ? 1 : 0;
    endfunction

    // Days in month mo (0 is January) of a year with the given leap flag.
    function automatic int unsigned month_len(input int unsigned mo, input int unsigned lp);
        int unsigned len;
        case (mo)
            1:             len = 28 + lp;
            3, 5, 8, 10:   len = 30;
            default:       len = 31;
        endcase
        return len;
    endfunction

    // The date predictor: splits the count into days and time of day, walks
    // years from 1970 and then months of the year reached.
    function automatic civil_t civil_from_seconds(input logic [31:0] stamp);
        civil_t      r;
        int unsigned secs;
        int unsigned days;
        int unsigned yr;
        int unsigned leaps;
        int unsigned lp;
        int unsigned mo;
        secs     = stamp;
        r.second = 6'(secs % 60);
        r.minute = 6'((secs / 60) % 60);
        r.hour   = 5'((secs % SECS_IN_DAY) / SECS_IN_HOUR);
        days     = secs / SECS_IN_DAY;
        yr       = FIRST_YEAR;
        leaps    = 0;
        while (days >= 365 + leap_year(yr))
        begin
            days  -= 365 + leap_year(yr);
            leaps += leap_year(yr);
            yr++;
        end
        lp            = leap_year(yr);
        r.year        = 12'(yr);
        r.day_in_year = 9'(days + 1);
        r.leap_count  = 6'(leaps);
        mo = 0;
        while (mo < 11 && days >= month_len(mo, lp))
        begin
            days -= month_len(mo, lp);
            mo++;
        end
        r.month = 4'(mo + 1);
        r.day   = 5'(days + 1);
        return r;
    endfunction

    // A count within two days either side of the start of month mo of year yr.
    // Falls back to a uniform count when the chosen count leaves the 32-bit range.
    function automatic logic [31:0] near_month_start(input int unsigned yr,
                                                     input int unsigned mo);
        longint      t;
        int unsigned y;
        int unsigned m;
        t = 0;
        for (y = FIRST_YEAR; y < yr; y++)
        begin
            t += longint'(365 + leap_year(y)) * SECS_IN_DAY;
        end
        for (m = 0; m < mo; m++)
        begin
            t += longint'(month_len(m, leap_year(yr))) * SECS_IN_DAY;
        end
        t += longint'($urandom_range(0, 4 * SECS_IN_DAY)) - 2 * SECS_IN_DAY;
        if (t < 0 || t > LARGEST_STAMP)
        begin
            t = $urandom;
        end
        return t[31:0];
    endfunction

    // ---------------------------------------------------------------------
    // Clock, reset and the stamp side.
    // ---------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2.0) clk = ~clk;
        end
    end

    // Sends one count: possibly after a burst of idle cycles, then holds valid
    // until the block takes it. The owed date is queued at the transfer edge.
    // Valid is left high so that back-to-back transfers need no second write.
    task automatic send_stamp(input logic [31:0] stamp, input civil_t date);
        int unsigned gap;
        owed_date_t  owed;
        if (idle_rate != 0 && $urandom_range(0, idle_rate) == 0)
        begin
            gap = $urandom_range(1, MAX_BURST);
            stamp_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stamp_ch.valid         <= 1'b1;
        stamp_ch.epoch_seconds <= stamp;
        do
        begin
            @(posedge clk);
        end
        while (!stamp_ch.ready);
        owed.stamp = stamp;
        owed.date  = date;
        owed_dates.push_back(owed);
    endtask

    // Random counts: half uniform over the whole range, the rest aimed at month
    // and year starts, at the leap and century years, and at the top of the range.
    function automatic logic [31:0] random_stamp();
        int unsigned kind;
        int unsigned yr;
        logic [31:0] stamp;
        kind = $urandom_range(0, 9);
        if (kind <= 4)
        begin
            stamp = $urandom;
        end
        else if (kind <= 7)
        begin
            stamp = near_month_start($urandom_range(FIRST_YEAR, LAST_YEAR),
                                     $urandom_range(0, 11));
        end
        else if (kind == 8)
        begin
            case ($urandom_range(0, 5))
                0:       yr = 1972;
                1:       yr = 2000;
                2:       yr = 2099;
                3:       yr = 2100;
                4:       yr = 2101;
                default: yr = 2104;
            endcase
            stamp = near_month_start(yr, $urandom_range(0, 2));
        end
        else
        begin
            stamp = 32'hFFFF_FFFF - $urandom_range(0, 60 * SECS_IN_DAY);
        end
        return stamp;
    endfunction

    initial
    begin
        int unsigned row;
        int unsigned drained;
        civil_t      date;
        logic [31:0] stamp;

        error_count     = 0;
        dates_checked   = 0;
        random_sent     = 0;
        first_year_seen = LAST_YEAR;
        last_year_seen  = FIRST_YEAR;
        leap_days_seen  = 0;
        idle_rate       = 3;
        rst_n                  <= 1'b0;
        stamp_ch.valid         <= 1'b0;
        stamp_ch.epoch_seconds <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table first: typed dates where they are known by hand.
        for (row = 0; row < NUM_ROWS; row++)
        begin
            if (directed_rows[row].known_date)
            begin
                date = directed_rows[row].date;
            end
            else
            begin
                date = civil_from_seconds(directed_rows[row].stamp);
            end
            send_stamp(directed_rows[row].stamp, date);
        end

        // Random part. The idling density changes every fifty transfers, with
        // some stretches of none, and the last stretch runs at full rate.
        for (random_sent = 0; random_sent < RANDOM_ITEMS; random_sent++)
        begin
            if (random_sent >= RANDOM_ITEMS - CALM_TAIL)
            begin
                idle_rate = 0;
            end
            else if (random_sent % 50 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       idle_rate = 0;
                    1:       idle_rate = 2;
                    default: idle_rate = 6;
                endcase
            end
            stamp = random_stamp();
            send_stamp(stamp, civil_from_seconds(stamp));
        end
        stamp_ch.valid <= 1'b0;

        // Drain: wait for every owed date, then give the pipeline time to show
        // any stray result.
        while (owed_dates.size() != 0)
        begin
            @(posedge clk);
        end
        for (drained = 0; drained < DRAIN_CYCLES; drained++)
        begin
            @(posedge clk);
        end

        $display("Checked %0d dates (%0d directed, %0d random), years %0d to %0d, %0d leap days.",
                 dates_checked, NUM_ROWS, RANDOM_ITEMS, first_year_seen, last_year_seen,
                 leap_days_seen);
        $display("Errors: %0d.", error_count);
        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // ---------------------------------------------------------------------
    // Civil side: random stalls on ready and the check of every transfer.
    // ---------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        civil_t     got;
        owed_date_t owed;
        if (!rst_n)
        begin
            civil_ch.ready <= 1'b0;
            stall_left     = 0;
        end
        else
        begin
            if (civil_ch.valid && civil_ch.ready)
            begin
                got.year        = civil_ch.year;
                got.month       = civil_ch.month;
                got.day         = civil_ch.day;
                got.hour        = civil_ch.hour;
                got.minute      = civil_ch.minute;
                got.second      = civil_ch.second;
                got.day_in_year = civil_ch.day_in_year;
                got.leap_count  = civil_ch.leap_count;
                if (owed_dates.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("%0t: date with no count pending: %0d-%0d-%0d", $realtime,
                                 got.year, got.month, got.day);
                    end
                end
                else
                begin
                    owed = owed_dates.pop_front();
                    dates_checked++;
                    if (got.year        !== owed.date.year   ||
                        got.month       !== owed.date.month  ||
                        got.day         !== owed.date.day    ||
                        got.hour        !== owed.date.hour   ||
                        got.minute      !== owed.date.minute ||
                        got.second      !== owed.date.second ||
                        got.day_in_year !== owed.date.day_in_year ||
                        got.leap_count  !== owed.date.leap_count)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                        begin
                            $display("%0t: count %0d: expected %0d-%0d-%0d %0d:%0d:%0d doy %0d leaps %0d",
                                     $realtime, owed.stamp, owed.date.year, owed.date.month,
                                     owed.date.day, owed.date.hour, owed.date.minute,
                                     owed.date.second, owed.date.day_in_year,
                                     owed.date.leap_count);
                            $display("    got %0d-%0d-%0d %0d:%0d:%0d doy %0d leaps %0d",
                                     got.year, got.month, got.day, got.hour, got.minute,
                                     got.second, got.day_in_year, got.leap_count);
                        end
                    end
                    if (owed.date.year < first_year_seen)
                    begin
                        first_year_seen = owed.date.year;
                    end
                    if (owed.date.year > last_year_seen)
                    begin
                        last_year_seen = owed.date.year;
                    end
                    if (owed.date.month == 2 && owed.date.day == 29)
                    begin
                        leap_days_seen++;
                    end
                end
            end

            // Ready drops in random bursts, held low by stall_left; one write per edge.
            if (stall_left != 0)
            begin
                stall_left--;
                civil_ch.ready <= 1'b0;
            end
            else if (idle_rate != 0 && $urandom_range(0, idle_rate + 2) == 0)
            begin
                stall_left     = $urandom_range(1, MAX_BURST) - 1;
                civil_ch.ready <= 1'b0;
            end
            else
            begin
                civil_ch.ready <= 1'b1;
            end
        end
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Run timed out with %0d dates still owed.", owed_dates.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
